### design/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants for the command frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int COUNT_W    = 5;
  localparam int SETTINGS_W = 15;
  localparam int HEAD_DEPTH = 4;
  localparam int HEAD_IDX_W = 2;

  localparam logic [BYTE_W-1:0]  END_FIRST   = 8'hFE;
  localparam logic [BYTE_W-1:0]  END_SECOND  = 8'hFD;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 5'd18;
  localparam logic [COUNT_W-1:0] FRAME_LEN   = 5'd6;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_REJECT   = 3'd1,
    EV_OVERFLOW = 3'd2,
    EV_STATUS   = 3'd3,
    EV_UPDATE   = 3'd4,
    EV_BOTH     = 3'd5
  } event_t;

  typedef logic [HEAD_DEPTH-1:0][BYTE_W-1:0] head_t;

  // Decision for one byte, handed from the decoder to the state registers.
  typedef struct packed {
    logic               head_we;
    logic [COUNT_W-1:0] count_nxt;
    logic               update;
    event_t             ev;
  } step_t;

endpackage

`default_nettype wire

### design/cfr_in_reg.sv
// ----------------------------------------------------------------------------
// cfr_in_reg
// Input register: holds one received byte until the decode stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_in_reg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [cfr_pkg::BYTE_W-1:0] in_rx_byte,
  input  wire logic                      advance,
  output logic                           byte_valid,
  output logic [cfr_pkg::BYTE_W-1:0]     byte_data
);

  logic                       valid_r;
  logic                       valid_nxt;
  logic [cfr_pkg::BYTE_W-1:0] byte_r;

  // The register refills in the same cycle that its word moves on.
  assign in_stall  = valid_r && !advance;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_r <= in_rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

`default_nettype wire

### design/cfr_decode.sv
// ----------------------------------------------------------------------------
// cfr_decode
// Frame decoder: terminator detection, address and checksum checks, overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_decode (
  input  wire logic [cfr_pkg::BYTE_W-1:0]  rx_byte,
  input  wire logic [cfr_pkg::BYTE_W-1:0]  prev_byte,
  input  wire logic [cfr_pkg::COUNT_W-1:0] count,
  input  wire cfr_pkg::head_t              head,
  input  wire logic [cfr_pkg::BYTE_W-1:0]  device_address,
  output cfr_pkg::step_t                   step
);

  logic [cfr_pkg::COUNT_W-1:0] cnt_inc;
  logic [cfr_pkg::BYTE_W-1:0]  sum;
  logic [cfr_pkg::BYTE_W-1:0]  neg_sum;
  logic                        term;
  logic                        checked;
  logic                        status;
  logic                        update;

  always_comb begin
    cnt_inc = count + 5'd1;
    sum     = head[0] + head[1] + head[2];
    neg_sum = ~sum + 8'd1;
    // The previous byte belongs to this frame only once the count is nonzero.
    term    = (count != '0) && (prev_byte == cfr_pkg::END_FIRST) &&
              (rx_byte == cfr_pkg::END_SECOND);
    checked = term && (cnt_inc == cfr_pkg::FRAME_LEN) && (head[0] == device_address);
    status  = checked && (head[0] == head[1]) && (head[1] == head[2]) &&
              (head[2] == head[3]);
    update  = checked && (neg_sum == head[3]);

    step.head_we   = (count < 5'(cfr_pkg::HEAD_DEPTH));
    step.update    = update;
    step.count_nxt = cnt_inc;
    step.ev        = cfr_pkg::EV_NONE;

    if (term) begin
      step.count_nxt = '0;
      if (status && update) begin
        step.ev = cfr_pkg::EV_BOTH;
      end else if (status) begin
        step.ev = cfr_pkg::EV_STATUS;
      end else if (update) begin
        step.ev = cfr_pkg::EV_UPDATE;
      end else begin
        step.ev = cfr_pkg::EV_REJECT;
      end
    end else if (cnt_inc > cfr_pkg::COUNT_LIMIT) begin
      step.count_nxt = '0;
      step.ev        = cfr_pkg::EV_OVERFLOW;
    end
  end

endmodule

`default_nettype wire

### design/command_frame_receiver.sv
// ----------------------------------------------------------------------------
// command_frame_receiver
// Counts serial bytes into frames and reports status requests and settings
// updates, one result word for every byte.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | in_rx_byte[7:0]
//  out     | out_valid / out_stall| out_frame_event[2:0], out_settings_word[14:0]
//  cfg     | cfg_wr_en            | cfg_wr_data[7:0] (device address)
//
// One byte per cycle is sustained while out_stall is low; an accepted byte goes
// into the input register, then is decoded into the result register.
// The frame state updates in the same cycle that a result is loaded.
// Reset is synchronous and clears the count, the settings word, the address
// and both valid flags. A stall on the output holds the result register and
// backs up into the input register; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_receiver (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [cfr_pkg::BYTE_W-1:0]     in_rx_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [2:0]                         out_frame_event,
  output logic [cfr_pkg::SETTINGS_W-1:0]     out_settings_word,
  input  wire logic                          cfg_wr_en,
  input  wire logic [cfr_pkg::BYTE_W-1:0]     cfg_wr_data
);

  logic                           byte_valid;
  logic [cfr_pkg::BYTE_W-1:0]     byte_data;
  logic                           out_free;
  logic                           fire;
  cfr_pkg::step_t                 step;

  logic [cfr_pkg::BYTE_W-1:0]     addr_r;
  logic [cfr_pkg::COUNT_W-1:0]    count_r;
  logic [cfr_pkg::BYTE_W-1:0]     prev_r;
  cfr_pkg::head_t                 head_r;
  logic [cfr_pkg::SETTINGS_W-1:0] settings_r;
  logic [cfr_pkg::SETTINGS_W-1:0] settings_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  cfr_pkg::event_t                ev_r;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = byte_valid && out_free;

  cfr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .advance    (out_free),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  cfr_decode u_decode (
    .rx_byte        (byte_data),
    .prev_byte      (prev_r),
    .count          (count_r),
    .head           (head_r),
    .device_address (addr_r),
    .step           (step)
  );

  always_comb begin
    settings_nxt = settings_r;
    if (step.update) begin
      settings_nxt = {head_r[1], head_r[2][6:0]};
    end
    out_valid_nxt = out_free ? fire : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      count_r     <= '0;
      settings_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        addr_r <= cfg_wr_data;
      end
      if (fire) begin
        count_r    <= step.count_nxt;
        settings_r <= settings_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Frame bytes and the result payload carry no reset.
  always_ff @(posedge clk) begin
    if (fire) begin
      prev_r <= byte_data;
      ev_r   <= step.ev;
      if (step.head_we) begin
        head_r[count_r[cfr_pkg::HEAD_IDX_W-1:0]] <= byte_data;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_frame_event   = ev_r;
  assign out_settings_word = settings_r;

endmodule

`default_nettype wire

### design/cfr_checker.sv
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks for the command frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [2:0]                    out_frame_event,
  input wire logic [cfr_pkg::SETTINGS_W-1:0] out_settings_word
);

  logic                           last_vld_r;
  logic [cfr_pkg::SETTINGS_W-1:0] last_set_r;
  logic                           no_update;

  // Settings word of the most recently delivered result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_vld_r <= 1'b0;
    end else if (out_valid && !out_stall) begin
      last_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_stall) begin
      last_set_r <= out_settings_word;
    end
  end

  assign no_update = (out_frame_event == cfr_pkg::EV_NONE) ||
                     (out_frame_event == cfr_pkg::EV_REJECT) ||
                     (out_frame_event == cfr_pkg::EV_OVERFLOW) ||
                     (out_frame_event == cfr_pkg::EV_STATUS);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frame_event) &&
                               $stable(out_settings_word))
    else $error("stalled result changed");

  a_event_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_event <= cfr_pkg::EV_BOTH)
    else $error("undefined frame event code");

  // Only an update event (EV_UPDATE or EV_BOTH) may change the settings word between results.
  a_settings_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_vld_r && no_update |-> out_settings_word == last_set_r)
    else $error("settings word changed without an update");

endmodule

bind command_frame_receiver cfr_checker u_cfr_checker (.*);

`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// Command frame receiver testbench
// Feeds byte streams made of frames of many kinds (settings updates,
// status requests, bad checksums, foreign addresses, odd lengths, overflows
// and line noise) under several device addresses. Every result word is
// compared against a cycle-free model of the frame state, with random
// sender gaps and receiver stalls on both channels.
// ----------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cfr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_SETTLE = 6;
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 280;
  localparam int LONG_HOLD   = 120;
  localparam int HOLD_AFTER  = 200;

  typedef enum int {
    FR_UPDATE,
    FR_STATUS,
    FR_BAD_SUM,
    FR_BAD_ADDR,
    FR_ODD_LEN,
    FR_OVERFLOW,
    FR_NOISE,
    FR_EARLY_END
  } frame_kind_t;

  typedef struct {
    event_t                ev;
    logic [SETTINGS_W-1:0] word;
  } report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [2:0]            out_frame_event;
  logic [SETTINGS_W-1:0] out_settings_word;
  logic                  cfg_wr_en = 1'b0;
  logic [BYTE_W-1:0]     cfg_wr_data = '0;

  // Model of the frame state.
  logic [BYTE_W-1:0]     head_mem [HEAD_DEPTH];
  logic [BYTE_W-1:0]     last_byte = '0;
  logic [COUNT_W-1:0]    frame_cnt = '0;
  logic [SETTINGS_W-1:0] settings_cur = '0;
  logic [BYTE_W-1:0]     dev_addr = '0;

  logic [BYTE_W-1:0] byte_q [$];
  report_t           expected_reports [$];

  int   bytes_queued = 0;
  int   bytes_accepted = 0;
  int   reports_seen = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  int   ev_seen [6] = '{default: 0};
  int   send_gap = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  bit   quiet = 1'b0;
  bit   in_accepted = 1'b0;
  int   phase;
  logic [BYTE_W-1:0] phase_address;

  command_frame_receiver u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_frame_event   (out_frame_event),
    .out_settings_word (out_settings_word),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Advances the frame state by one byte and records the word it should give.
  task automatic absorb_byte(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] sum;
    logic              is_status;
    logic              is_update;
    report_t           rep;
    begin
      rep.ev = EV_NONE;
      if (frame_cnt < HEAD_DEPTH) head_mem[frame_cnt[HEAD_IDX_W-1:0]] = b;
      frame_cnt = frame_cnt + 1'b1;
      if (frame_cnt > 1 && last_byte == END_FIRST && b == END_SECOND) begin
        is_status = 1'b0;
        is_update = 1'b0;
        if (frame_cnt == FRAME_LEN && head_mem[0] == dev_addr) begin
          sum = head_mem[0] + head_mem[1] + head_mem[2];
          is_status = head_mem[0] == head_mem[1] && head_mem[1] == head_mem[2] &&
                      head_mem[2] == head_mem[3];
          is_update = (8'h00 - sum) == head_mem[3];
        end
        if (is_update) settings_cur = {head_mem[1], head_mem[2][6:0]};
        if (is_status && is_update) begin
          rep.ev = EV_BOTH;
        end else if (is_status) begin
          rep.ev = EV_STATUS;
        end else if (is_update) begin
          rep.ev = EV_UPDATE;
        end else begin
          rep.ev = EV_REJECT;
        end
        frame_cnt = '0;
      end
      if (frame_cnt > COUNT_LIMIT) begin
        frame_cnt = '0;
        rep.ev = EV_OVERFLOW;
      end
      last_byte = b;
      rep.word = settings_cur;
      expected_reports.push_back(rep);
    end
  endtask

  function automatic int pick_gap();
    int r;
    begin
      r = $urandom_range(0, 99);
      if (quiet || r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
    end
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    begin
      byte_q.push_back(b);
      bytes_queued++;
    end
  endtask

  task automatic push_end();
    begin
      push_byte(END_FIRST);
      push_byte(END_SECOND);
    end
  endtask

  task automatic queue_directed();
    int k;
    begin
      // Address zero makes the all-zero frame pass both checks.
      repeat (4) push_byte(8'h00);
      push_end();
      push_byte(8'h00);
      push_byte(8'hFF);
      for (k = 0; k < 16; k++) push_byte(8'($urandom_range(0, 8'hFC)));
      // The nineteenth byte overflows the count, so the following 0xFD
      // opens a new frame instead of ending one.
      push_byte(END_FIRST);
      push_byte(END_SECOND);
      push_end();
    end
  endtask

  task automatic queue_frames(input int n_items, input logic [BYTE_W-1:0] addr);
    int                start;
    int                r;
    int                len;
    int                k;
    logic [BYTE_W-1:0] a;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    frame_kind_t       kind;
    begin
      start = bytes_queued;
      while (bytes_queued - start < n_items) begin
        r = $urandom_range(0, 99);
        if (r < 30) kind = FR_UPDATE;
        else if (r < 40) kind = FR_STATUS;
        else if (r < 50) kind = FR_BAD_SUM;
        else if (r < 58) kind = FR_BAD_ADDR;
        else if (r < 70) kind = FR_ODD_LEN;
        else if (r < 78) kind = FR_OVERFLOW;
        else if (r < 92) kind = FR_NOISE;
        else kind = FR_EARLY_END;
        b1 = 8'($urandom_range(0, 255));
        b2 = 8'($urandom_range(0, 255));
        case (kind)
          FR_UPDATE, FR_BAD_SUM, FR_BAD_ADDR: begin
            a = addr;
            if (kind == FR_BAD_ADDR) a = addr ^ 8'($urandom_range(1, 255));
            push_byte(a);
            push_byte(b1);
            push_byte(b2);
            if (kind == FR_BAD_SUM) begin
              push_byte(8'h00 - (a + b1 + b2) + 8'($urandom_range(1, 255)));
            end else begin
              push_byte(8'h00 - (a + b1 + b2));
            end
            push_end();
          end
          FR_STATUS: begin
            repeat (4) push_byte(addr);
            push_end();
          end
          FR_ODD_LEN: begin
            len = $urandom_range(0, 16);
            for (k = 0; k < len; k++) push_byte(8'($urandom_range(0, 255)));
            push_end();
          end
          FR_OVERFLOW: begin
            len = $urandom_range(19, 24);
            for (k = 0; k < len; k++) push_byte(8'($urandom_range(0, 8'hFC)));
            push_end();
          end
          FR_NOISE: begin
            len = $urandom_range(1, 6);
            for (k = 0; k < len; k++) begin
              if ($urandom_range(0, 99) < 35) begin
                push_byte($urandom_range(0, 1) ? END_FIRST : END_SECOND);
              end else begin
                push_byte(8'($urandom_range(0, 255)));
              end
            end
            // The trailing pair brings the count back to the start of a frame.
            push_end();
          end
          default: begin
            push_byte(addr);
            push_end();
            push_byte(b1);
            push_end();
          end
        endcase
      end
    end
  endtask

  task automatic wait_for_idle();
    begin
      while (bytes_accepted != bytes_queued || expected_reports.size() != 0) begin
        @(negedge clk);
      end
      repeat (PIPE_SETTLE) @(negedge clk);
    end
  endtask

  // Sender: a word stays on the port until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_accepted) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (byte_q.size() > 0) begin
        in_rx_byte <= byte_q.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs up the input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && reports_seen >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    report_t rep;
    cycle_count++;
    if (rst_n && cfg_wr_en) dev_addr = cfg_wr_data;
    in_accepted = rst_n && in_valid && !in_stall;
    if (in_accepted) begin
      absorb_byte(in_rx_byte);
      bytes_accepted++;
    end
    if (rst_n && out_valid && !out_stall) begin
      reports_seen++;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected word: event %0d, settings %h", $time,
                 out_frame_event, out_settings_word);
        mismatches++;
      end else begin
        rep = expected_reports.pop_front();
        ev_seen[rep.ev]++;
        if (out_frame_event !== rep.ev) begin
          $display("%0t: frame_event expected %0d, actual %0d", $time,
                   rep.ev, out_frame_event);
          mismatches++;
        end
        if (out_settings_word !== rep.word) begin
          $display("%0t: settings_word expected %h, actual %h", $time,
                   rep.word, out_settings_word);
          mismatches++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles", $time, cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_for_idle();
      case (phase)
        0: phase_address = 8'h00;
        1: phase_address = 8'hFF;
        2: phase_address = 8'h80;
        4: phase_address = 8'h40;
        default: phase_address = 8'($urandom_range(0, 255));
      endcase
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_wr_data <= phase_address;
      @(negedge clk);
      cfg_wr_en <= 1'b0;
      quiet = (phase == 1 || phase == 4);
      if (phase == 0) begin
        queue_directed();
      end else begin
        queue_frames(PHASE_ITEMS, phase_address);
      end
    end
    wait_for_idle();
    $display("Checked %0d result words for %0d bytes under %0d device addresses.",
             reports_seen, bytes_accepted, NUM_PHASES);
    $display("Frame ends: %0d rejected, %0d overflow, %0d status, %0d update, %0d both.",
             ev_seen[EV_REJECT], ev_seen[EV_OVERFLOW], ev_seen[EV_STATUS],
             ev_seen[EV_UPDATE], ev_seen[EV_BOTH]);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
